FILE: hdl/greedy_box_nms_assert.svh
// Assertion helpers for the box suppression block.
// Used by modules that have clk_i and rst_ni in scope.
`ifndef GREEDY_BOX_NMS_ASSERT_SVH
`define GREEDY_BOX_NMS_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define GBN_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: hdl/gbn_pkg.sv
// Shared types, constants and helper functions of the box suppression block.
// No dependencies.
package gbn_pkg;

  localparam int MaxBoxesDef = 64;
  localparam int ResultSlots = 64;
  localparam int IdxW        = 6;
  localparam int ThrW        = 17;
  localparam logic [ThrW-1:0] ThrReset = 17'd32768;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [15:0]        score;
    logic [7:0]         tag;
  } box_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_we;
    logic rd_en;
    logic pass_start;
    logic take_best;
    logic have_best;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
    logic cand_found;
  } sts_t;

  // Extent hi - lo, clamped at zero; always fits 16 bits unsigned.
  function automatic logic [15:0] span(logic signed [15:0] hi, logic signed [15:0] lo);
    logic signed [16:0] d;
    d = $signed({hi[15], hi}) - $signed({lo[15], lo});
    return d[16] ? 16'd0 : d[15:0];
  endfunction

  function automatic logic signed [15:0] smin(logic signed [15:0] a, logic signed [15:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [15:0] smax(logic signed [15:0] a, logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: hdl/greedy_box_nms.sv
// Top level of the greedy box suppression block.
// Depends on gbn_pkg, gbn_ctrl, gbn_dp and gbn_ram.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o | box edges, score, tag, final
//   out     | output    | out_valid_o/out_ready_i | kept box, index, end, overflow
//   cfg     | input     | cfg_we_i                | cfg_wdata_i (IoU threshold)
//
// A non-final box is stored as it is accepted. A final box starts suppression.
// Each pass reads the N loaded boxes in turn through the single read port,
// drains the five stage overlap pipeline and then decides. A pick costs one
// pass plus a result handshake, and one extra pass at the start finds the
// first pick. Input stays closed until the last result of the set is taken;
// an output stall holds the block in its result state. Reset is asynchronous,
// active low.
module greedy_box_nms #(
  parameter int MaxBoxes = gbn_pkg::MaxBoxesDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gbn_pkg::ThrW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [15:0]       box_left_i,
  input  logic signed [15:0]       box_top_i,
  input  logic signed [15:0]       box_right_i,
  input  logic signed [15:0]       box_bottom_i,
  input  logic [15:0]              score_i,
  input  logic [7:0]               tag_i,
  input  logic                     final_box_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       kept_left_o,
  output logic signed [15:0]       kept_top_o,
  output logic signed [15:0]       kept_right_o,
  output logic signed [15:0]       kept_bottom_o,
  output logic [15:0]              kept_score_o,
  output logic [7:0]               kept_tag_o,
  output logic [5:0]               load_index_o,
  output logic                     end_of_run_o,
  output logic                     overflow_o
);

  localparam int AW = $clog2(MaxBoxes);

  gbn_pkg::cmd_t cmd;
  gbn_pkg::sts_t sts;
  gbn_pkg::box_t in_box, best_box;
  logic [AW-1:0] load_addr, rd_addr, best_idx;

  assign in_box.left   = box_left_i;
  assign in_box.top    = box_top_i;
  assign in_box.right  = box_right_i;
  assign in_box.bottom = box_bottom_i;
  assign in_box.score  = score_i;
  assign in_box.tag    = tag_i;

  gbn_ctrl #(.MaxBoxes(MaxBoxes)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .final_box_i  (final_box_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .end_of_run_o (end_of_run_o),
    .overflow_o   (overflow_o),
    .cmd_o        (cmd),
    .sts_i        (sts),
    .load_addr_o  (load_addr),
    .rd_addr_o    (rd_addr)
  );

  gbn_dp #(.MaxBoxes(MaxBoxes)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .load_addr_i (load_addr),
    .rd_addr_i   (rd_addr),
    .in_box_i    (in_box),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .best_box_o  (best_box),
    .best_idx_o  (best_idx)
  );

  // Result fields come straight from the pick register.
  assign kept_left_o   = best_box.left;
  assign kept_top_o    = best_box.top;
  assign kept_right_o  = best_box.right;
  assign kept_bottom_o = best_box.bottom;
  assign kept_score_o  = best_box.score;
  assign kept_tag_o    = best_box.tag;
  assign load_index_o  = 6'(best_idx);

endmodule

FILE: hdl/gbn_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gbn_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gbn_dp.sv
// Datapath: box store, alive store, overlap pipeline and pick registers.
// Depends on gbn_pkg and gbn_ram.
module gbn_dp #(
  parameter int MaxBoxes = gbn_pkg::MaxBoxesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbn_pkg::cmd_t               cmd_i,
  output gbn_pkg::sts_t               sts_o,
  input  logic [$clog2(MaxBoxes)-1:0] load_addr_i,
  input  logic [$clog2(MaxBoxes)-1:0] rd_addr_i,
  input  gbn_pkg::box_t               in_box_i,
  input  logic                        cfg_we_i,
  input  logic [gbn_pkg::ThrW-1:0]    cfg_wdata_i,
  output gbn_pkg::box_t               best_box_o,
  output logic [$clog2(MaxBoxes)-1:0] best_idx_o
);

  localparam int AW = $clog2(MaxBoxes);

  logic [gbn_pkg::ThrW-1:0] thr_q;

  gbn_pkg::box_t  box_rd;
  logic           alive_rd;
  logic           alive_we;
  logic [AW-1:0]  alive_waddr;
  logic           alive_wdata;

  // Pick registers: current best and next candidate.
  gbn_pkg::box_t  best_box_q, cand_box_q;
  logic [AW-1:0]  best_idx_q, cand_idx_q;
  logic [31:0]    best_area_q, cand_area_q;
  logic           cand_found_q;

  // Pipeline stage registers.
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [AW-1:0] idx1_q, idx2_q, idx3_q, idx4_q, idx5_q;
  logic alive2_q, alive3_q, alive4_q, alive5_q;
  gbn_pkg::box_t box2_q, box3_q, box4_q, box5_q;
  logic [15:0] wb2_q, hb2_q, iw2_q, ih2_q;
  logic [31:0] area3_q, inter3_q, area4_q, inter4_q, area5_q, inter5_q;
  logic [32:0] uni4_q;
  logic [33:0] plo5_q;
  logic [32:0] phi5_q;
  logic        zero5_q;

  logic [15:0] wb_c, hb_c, iw_c, ih_c;
  logic [49:0] lhs5, rhs5;
  logic        kill5, hit5, survive5, better5;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= gbn_pkg::ThrReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  gbn_ram #(.Width($bits(gbn_pkg::box_t)), .Depth(MaxBoxes)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (load_addr_i),
    .wdata_i (in_box_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (box_rd)
  );

  gbn_ram #(.Width(1), .Depth(MaxBoxes)) u_alive_ram (
    .clk_i   (clk_i),
    .we_i    (alive_we),
    .waddr_i (alive_waddr),
    .wdata_i (alive_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (alive_rd)
  );

  // Stage one: extents of the box read and of its overlap with the best box.
  always_comb begin
    wb_c = gbn_pkg::span(box_rd.right, box_rd.left);
    hb_c = gbn_pkg::span(box_rd.bottom, box_rd.top);
    iw_c = gbn_pkg::span(gbn_pkg::smin(best_box_q.right, box_rd.right),
                         gbn_pkg::smax(best_box_q.left, box_rd.left));
    ih_c = gbn_pkg::span(gbn_pkg::smin(best_box_q.bottom, box_rd.bottom),
                         gbn_pkg::smax(best_box_q.top, box_rd.top));
  end

  // Pipeline valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Pipeline payload: areas, union, then the two threshold partial products.
  always_ff @(posedge clk_i) begin
    idx1_q   <= rd_addr_i;
    idx2_q   <= idx1_q;
    alive2_q <= alive_rd;
    box2_q   <= box_rd;
    wb2_q    <= wb_c;
    hb2_q    <= hb_c;
    iw2_q    <= iw_c;
    ih2_q    <= ih_c;

    idx3_q   <= idx2_q;
    alive3_q <= alive2_q;
    box3_q   <= box2_q;
    area3_q  <= wb2_q * hb2_q;
    inter3_q <= iw2_q * ih2_q;

    idx4_q   <= idx3_q;
    alive4_q <= alive3_q;
    box4_q   <= box3_q;
    area4_q  <= area3_q;
    inter4_q <= inter3_q;
    uni4_q   <= 33'(best_area_q) + 33'(area3_q) - 33'(inter3_q);

    idx5_q   <= idx4_q;
    alive5_q <= alive4_q;
    box5_q   <= box4_q;
    area5_q  <= area4_q;
    inter5_q <= inter4_q;
    zero5_q  <= (uni4_q == 33'd0);
    plo5_q   <= thr_q * uni4_q[16:0];
    phi5_q   <= thr_q * uni4_q[32:17];
  end

  // Stage five: suppression test, inter * 65536 >= thr * union (with a zero union, only a zero threshold suppresses).
  always_comb begin
    lhs5     = {2'b00, inter5_q, 16'd0};
    rhs5     = 50'(plo5_q) + (50'(phi5_q) << 17);
    kill5    = zero5_q ? (thr_q == '0) : (lhs5 >= rhs5);
    hit5     = cmd_i.have_best && (kill5 || (idx5_q == best_idx_q));
    survive5 = alive5_q && !hit5;
    better5  = !cand_found_q || (box5_q.score > cand_box_q.score);
  end

  // Alive store: set on load, cleared for the best box and suppressed boxes.
  always_comb begin
    if (cmd_i.load_we) begin
      alive_we    = 1'b1;
      alive_waddr = load_addr_i;
      alive_wdata = 1'b1;
    end else begin
      alive_we    = v5_q && alive5_q && hit5;
      alive_waddr = idx5_q;
      alive_wdata = 1'b0;
    end
  end

  // Candidate tracking; strict compare keeps the earlier box on ties.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_found_q <= 1'b0;
    end else if (cmd_i.pass_start) begin
      cand_found_q <= 1'b0;
    end else if (v5_q && survive5) begin
      cand_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v5_q && survive5 && better5 && !cmd_i.pass_start) begin
      cand_box_q  <= box5_q;
      cand_idx_q  <= idx5_q;
      cand_area_q <= area5_q;
    end
    if (cmd_i.take_best) begin
      best_box_q  <= cand_box_q;
      best_idx_q  <= cand_idx_q;
      best_area_q <= cand_area_q;
    end
  end

  assign sts_o.busy       = v1_q | v2_q | v3_q | v4_q | v5_q;
  assign sts_o.cand_found = cand_found_q;
  assign best_box_o       = best_box_q;
  assign best_idx_o       = best_idx_q;

endmodule

FILE: hdl/gbn_ctrl.sv
// Controller: load counting, pass sequencing and result handshake.
// Depends on gbn_pkg and greedy_box_nms_assert.svh.
`include "greedy_box_nms_assert.svh"

module gbn_ctrl #(
  parameter int MaxBoxes = gbn_pkg::MaxBoxesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        final_box_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        end_of_run_o,
  output logic                        overflow_o,
  output gbn_pkg::cmd_t               cmd_o,
  input  gbn_pkg::sts_t               sts_i,
  output logic [$clog2(MaxBoxes)-1:0] load_addr_o,
  output logic [$clog2(MaxBoxes)-1:0] rd_addr_o
);

  localparam int AW = $clog2(MaxBoxes);
  localparam int CW = $clog2(MaxBoxes + 1);

  typedef enum logic [1:0] {
    StLoad,
    StPass,
    StOut
  } state_e;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [AW-1:0]           rd_q, rd_d;
  logic                    issuing_q, issuing_d;
  logic                    have_best_q, have_best_d;
  logic [gbn_pkg::IdxW-1:0] emit_q, emit_d;
  logic                    dropped_q, dropped_d;
  logic                    in_acc, out_acc, last_rd, end_run;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign last_rd = (CW'(rd_q) == cnt_q - CW'(1));
  assign end_run = !sts_i.cand_found ||
                   (emit_q == gbn_pkg::IdxW'(gbn_pkg::ResultSlots - 1));

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    issuing_d   = issuing_q;
    have_best_d = have_best_q;
    emit_d      = emit_q;
    dropped_d   = dropped_q;
    cmd_o       = '0;
    cmd_o.have_best = have_best_q;

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (cnt_q < CW'(MaxBoxes)) begin
            cmd_o.load_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (final_box_i) begin
            cmd_o.pass_start = 1'b1;
            state_d     = StPass;
            rd_d        = '0;
            issuing_d   = 1'b1;
            have_best_d = 1'b0;
          end
        end
      end
      StPass: begin
        if (issuing_q) begin
          cmd_o.rd_en = 1'b1;
          if (last_rd) begin
            issuing_d = 1'b0;
          end else begin
            rd_d = rd_q + AW'(1);
          end
        end else if (!sts_i.busy) begin
          if (!have_best_q) begin
            // First pass only finds the top box; run again to suppress.
            cmd_o.take_best  = 1'b1;
            cmd_o.pass_start = 1'b1;
            have_best_d = 1'b1;
            rd_d        = '0;
            issuing_d   = 1'b1;
          end else begin
            state_d = StOut;
          end
        end
      end
      StOut: begin
        if (out_acc) begin
          if (end_run) begin
            state_d     = StLoad;
            cnt_d       = '0;
            dropped_d   = 1'b0;
            emit_d      = '0;
            have_best_d = 1'b0;
          end else begin
            cmd_o.take_best  = 1'b1;
            cmd_o.pass_start = 1'b1;
            emit_d    = emit_q + gbn_pkg::IdxW'(1);
            rd_d      = '0;
            issuing_d = 1'b1;
            state_d   = StPass;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      rd_q        <= '0;
      issuing_q   <= 1'b0;
      have_best_q <= 1'b0;
      emit_q      <= '0;
      dropped_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      issuing_q   <= issuing_d;
      have_best_q <= have_best_d;
      emit_q      <= emit_d;
      dropped_q   <= dropped_d;
    end
  end

  assign in_ready_o   = (state_q == StLoad);
  assign out_valid_o  = (state_q == StOut);
  assign end_of_run_o = end_run;
  assign overflow_o   = dropped_q;
  assign load_addr_o  = cnt_q[AW-1:0];
  assign rd_addr_o    = rd_q;

  `GBN_NEVER(a_load_or_emit, in_ready_o && out_valid_o, "input and output open together")
  `GBN_ASSERT(a_rd_in_set, cmd_o.rd_en |-> (CW'(rd_addr_o) < cnt_q), "read past loaded boxes")
  `GBN_ASSERT(a_take_idle, cmd_o.take_best |-> !sts_i.busy, "pick taken while pipeline busy")
  `GBN_ASSERT(a_run_ends, (out_acc && end_of_run_o) |=> (in_ready_o && cnt_q == '0), "set not cleared")

endmodule

FILE: dv/nms_checker.sv
// Checker for the greedy box suppression block: predicts kept boxes per set.
// Depends on gbn_pkg; watches the in, out and cfg channels of the block.
module nms_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gbn_pkg::ThrW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  gbn_pkg::box_t            in_box_i,
  input  logic                     final_box_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  gbn_pkg::box_t            kept_box_i,
  input  logic [5:0]               load_index_i,
  input  logic                     end_of_run_i,
  input  logic                     overflow_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    gbn_pkg::box_t kept;
    logic [5:0]    idx;
    logic          last;
    logic          ovf;
  } kept_t;

  gbn_pkg::box_t             set_boxes[gbn_pkg::MaxBoxesDef];
  int                        set_size;
  logic                      set_dropped;
  logic [gbn_pkg::ThrW-1:0]  iou_thr;
  kept_t                     kept_queue[$];

  assign pending_o = kept_queue.size();

  function automatic longint clamp_pos(longint v);
    return v < 0 ? 0 : v;
  endfunction

  // True when box b overlaps box a at or above the threshold.
  function automatic bit overlaps(gbn_pkg::box_t a, gbn_pkg::box_t b,
                                  logic [gbn_pkg::ThrW-1:0] thr);
    longint area_a, area_b, iw, ih, inter, uni;
    area_a = clamp_pos(longint'(a.right) - a.left) * clamp_pos(longint'(a.bottom) - a.top);
    area_b = clamp_pos(longint'(b.right) - b.left) * clamp_pos(longint'(b.bottom) - b.top);
    iw = clamp_pos((a.right < b.right ? longint'(a.right) : longint'(b.right)) -
                   (a.left > b.left ? longint'(a.left) : longint'(b.left)));
    ih = clamp_pos((a.bottom < b.bottom ? longint'(a.bottom) : longint'(b.bottom)) -
                   (a.top > b.top ? longint'(a.top) : longint'(b.top)));
    inter = iw * ih;
    uni = area_a + area_b - inter;
    if (uni <= 0) return thr == 0;
    return inter * 65536 >= longint'(thr) * uni;
  endfunction

  // Greedy suppression over the stored set; queues the kept boxes in pick order.
  task automatic predict_kept();
    bit   alive[gbn_pkg::MaxBoxesDef];
    int   best;
    int   first;
    for (int i = 0; i < set_size; i++) alive[i] = 1;
    first = kept_queue.size();
    forever begin
      best = -1;
      for (int i = 0; i < set_size; i++)
        if (alive[i] && (best < 0 || set_boxes[i].score > set_boxes[best].score)) best = i;
      if (best < 0) break;
      alive[best] = 0;
      for (int i = 0; i < set_size; i++)
        if (alive[i] && overlaps(set_boxes[best], set_boxes[i], iou_thr)) alive[i] = 0;
      kept_queue.push_back('{kept: set_boxes[best], idx: best[5:0], last: 1'b0,
                             ovf: set_dropped});
    end
    if (kept_queue.size() > first) kept_queue[$].last = 1'b1;
    set_size = 0;
    set_dropped = 1'b0;
  endtask

  // Track configuration, loaded items and kept items.
  always @(posedge clk_i or negedge rst_ni) begin
    kept_t exp_k;
    if (!rst_ni) begin
      set_size = 0;
      set_dropped = 1'b0;
      iou_thr = gbn_pkg::ThrReset;
      kept_queue.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) iou_thr = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (kept_queue.size() == 0) begin
          $error("kept item with nothing expected");
          fail_count_o++;
        end else begin
          exp_k = kept_queue.pop_front();
          if (kept_box_i.left !== exp_k.kept.left) begin
            $error("kept_left exp %0d got %0d", exp_k.kept.left, kept_box_i.left);
            fail_count_o++;
          end
          if (kept_box_i.top !== exp_k.kept.top) begin
            $error("kept_top exp %0d got %0d", exp_k.kept.top, kept_box_i.top);
            fail_count_o++;
          end
          if (kept_box_i.right !== exp_k.kept.right) begin
            $error("kept_right exp %0d got %0d", exp_k.kept.right, kept_box_i.right);
            fail_count_o++;
          end
          if (kept_box_i.bottom !== exp_k.kept.bottom) begin
            $error("kept_bottom exp %0d got %0d", exp_k.kept.bottom, kept_box_i.bottom);
            fail_count_o++;
          end
          if (kept_box_i.score !== exp_k.kept.score) begin
            $error("kept_score exp %0d got %0d", exp_k.kept.score, kept_box_i.score);
            fail_count_o++;
          end
          if (kept_box_i.tag !== exp_k.kept.tag) begin
            $error("kept_tag exp %0d got %0d", exp_k.kept.tag, kept_box_i.tag);
            fail_count_o++;
          end
          if (load_index_i !== exp_k.idx) begin
            $error("load_index exp %0d got %0d", exp_k.idx, load_index_i);
            fail_count_o++;
          end
          if (end_of_run_i !== exp_k.last) begin
            $error("end_of_run exp %0b got %0b", exp_k.last, end_of_run_i);
            fail_count_o++;
          end
          if (overflow_i !== exp_k.ovf) begin
            $error("overflow exp %0b got %0b", exp_k.ovf, overflow_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (set_size < gbn_pkg::MaxBoxesDef) begin
          set_boxes[set_size] = in_box_i;
          set_size++;
        end else begin
          set_dropped = 1'b1;
        end
        if (final_box_i) predict_kept();
      end
    end
  end
endmodule

FILE: dv/tb.sv
// Testbench top for the greedy box suppression block: stimulus and verdict.
// Depends on gbn_pkg, greedy_box_nms and nms_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we;
  logic [gbn_pkg::ThrW-1:0]  cfg_wdata;
  logic                      in_valid, in_ready;
  gbn_pkg::box_t             in_box;
  logic                      final_box;
  logic                      out_valid, out_ready;
  gbn_pkg::box_t             kept_box;
  logic [5:0]                load_index;
  logic                      end_of_run, overflow;
  int                        fail_count, pending;
  int                        cycle_count;
  bit                        hold_off;

  greedy_box_nms dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .box_left_i(in_box.left), .box_top_i(in_box.top),
    .box_right_i(in_box.right), .box_bottom_i(in_box.bottom),
    .score_i(in_box.score), .tag_i(in_box.tag), .final_box_i(final_box),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kept_left_o(kept_box.left), .kept_top_o(kept_box.top),
    .kept_right_o(kept_box.right), .kept_bottom_o(kept_box.bottom),
    .kept_score_o(kept_box.score), .kept_tag_o(kept_box.tag),
    .load_index_o(load_index), .end_of_run_o(end_of_run), .overflow_o(overflow)
  );

  nms_checker checker_inst (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_box_i(in_box),
    .final_box_i(final_box),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .kept_box_i(kept_box),
    .load_index_i(load_index), .end_of_run_i(end_of_run), .overflow_i(overflow),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stalls on its own pattern; a long hold-off is applied on request.
  always @(posedge clk_i) begin
    if (hold_off) out_ready <= 1'b0;
    else if (cycle_count % 500 < 150) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Random box, mostly near a cluster so that overlaps are common.
  function automatic gbn_pkg::box_t rand_box(int cx, int cy);
    gbn_pkg::box_t b;
    int w, h;
    if ($urandom_range(0, 9) == 0) begin
      b = gbn_pkg::box_t'({$urandom(), $urandom(), $urandom()});
    end else begin
      w = $urandom_range(0, 4000);
      h = $urandom_range(0, 4000);
      b.left   = 16'(cx + $signed($urandom_range(0, 1200)) - 600);
      b.top    = 16'(cy + $signed($urandom_range(0, 1200)) - 600);
      b.right  = 16'(int'(b.left) + w);
      b.bottom = 16'(int'(b.top) + h);
      b.score  = 16'($urandom());
      if ($urandom_range(0, 4) == 0) b.score = 16'($urandom_range(0, 3));
      b.tag    = 8'($urandom());
    end
    return b;
  endfunction

  // Offer one item and wait for it to be taken.
  task automatic send_box(gbn_pkg::box_t b, logic last);
    in_valid  <= 1'b1;
    in_box    <= b;
    final_box <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  // Wait until every kept box has arrived and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // The threshold is only changed once the block has gone idle.
  task automatic write_thr(logic [gbn_pkg::ThrW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // A set of n boxes with bursty sending.
  task automatic send_set(int n);
    int cx, cy, burst;
    cx = $signed($urandom_range(0, 40000)) - 20000;
    cy = $signed($urandom_range(0, 40000)) - 20000;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      send_box(rand_box(cx, cy), i == n - 1);
      if (--burst == 0) begin
        if ($urandom_range(0, 1)) idle_gap();
        burst = $urandom_range(1, 8);
      end
    end
  endtask

  initial begin
    gbn_pkg::box_t b;
    int sent;
    logic [gbn_pkg::ThrW-1:0] thr_set[5];
    thr_set = '{17'd0, 17'd65536, 17'd65537, 17'd1, 17'd131071};
    rst_ni = 1'b0; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0; in_box = '0;
    final_box = 1'b0; out_ready = 1'b0; cycle_count = 0; hold_off = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, equal scores, zero area, single box at reset threshold.
    b = '{left: 16'sh8000, top: 16'sh8000, right: 16'sh7fff, bottom: 16'sh7fff,
          score: 16'hffff, tag: 8'hff};
    send_box(b, 1'b1);
    b = '{left: 16'sd0, top: 16'sd0, right: 16'sd100, bottom: 16'sd100,
          score: 16'd5, tag: 8'd1};
    send_box(b, 1'b0);
    b.tag = 8'd2;
    send_box(b, 1'b0);
    b = '{left: 16'sd50, top: 16'sd50, right: 16'sd50, bottom: 16'sd50,
          score: 16'd0, tag: 8'd3};
    send_box(b, 1'b0);
    b = '{left: 16'sh7fff, top: 16'sh7fff, right: 16'sh8000, bottom: 16'sh8000,
          score: 16'd5, tag: 8'd0};
    send_box(b, 1'b1);
    drain();
    write_thr(17'd0);
    send_box(b, 1'b0);
    send_box(b, 1'b1);
    drain();
    sent = 7;

    // Overflow: one set beyond capacity, with the receiver held off for a while.
    write_thr(17'd65536);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_set(gbn_pkg::MaxBoxesDef + 3);
    join
    drain();
    sent += gbn_pkg::MaxBoxesDef + 3;

    // Random sets across several thresholds.
    while (sent < 340) begin
      if ($urandom_range(0, 3) == 0) write_thr(thr_set[$urandom_range(0, 4)]);
      else if ($urandom_range(0, 3) == 0) write_thr(17'($urandom_range(0, 65536)));
      begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        send_set(n);
        sent += n;
      end
      if ($urandom_range(0, 2) == 0) drain();
    end
    drain();
    repeat (50) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
